>>> rtl/mexp_pkg.sv
// Package for the modular exponentiation core: field widths, the handshake
// structs between the sequencer and the remainder unit.
// No dependencies.
`default_nettype none

package mexp_pkg;

    localparam int BASE_W = 63;
    localparam int EXP_W  = 63;
    localparam int MOD_W  = 31;
    localparam int RES_W  = 31;
    localparam int PROD_W = 2 * MOD_W;
    localparam int DVD_W  = 63;
    localparam int CNT_W  = $clog2(DVD_W);

    // Request to the remainder unit
    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [MOD_W-1:0] modulus;
    } t_mod_ctl;

    // Status back from the remainder unit
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [MOD_W-1:0] rem;
    } t_mod_sts;

endpackage

`default_nettype wire

>>> rtl/mexp_if.sv
// Valid/ready channel interfaces for the modular exponentiation core.
// Depends on mexp_pkg for the field widths.
`default_nettype none

interface mexp_in_if;
    logic                          valid;
    logic                          ready;
    logic [mexp_pkg::BASE_W-1:0]   base_value;
    logic [mexp_pkg::EXP_W-1:0]    exponent_value;
    logic [mexp_pkg::MOD_W-1:0]    modulus;

    modport source (output valid, base_value, exponent_value, modulus, input ready);
    modport sink   (input valid, base_value, exponent_value, modulus, output ready);
endinterface

interface mexp_out_if;
    logic                          valid;
    logic                          ready;
    logic [mexp_pkg::RES_W-1:0]    result_value;
    logic                          modulus_error;

    modport source (output valid, result_value, modulus_error, input ready);
    modport sink   (input valid, result_value, modulus_error, output ready);
endinterface

`default_nettype wire

>>> rtl/modular_exponentiation_core.sv
// Modular exponentiation core: right-to-left square-and-multiply with one
// 31x31 multiplier and a shared bit-serial remainder unit (mexp_mod_unit).
// Depends on mexp_pkg and the channel interfaces in mexp_if.
//
// Usage:
//   i_in carries base_value, exponent_value and modulus; a word is taken when
//   valid and ready are both high. Ready is high only while the core is idle.
//   o_out carries result_value = base^exponent mod modulus and modulus_error.
//   A zero modulus gives modulus_error = 1 and result 0.
//   A zero exponent gives 1 for any nonzero modulus.
//
// Sequence: the remainder unit works one dividend bit per cycle. The base
//   is reduced first; each multiply or square then forms the product, starts
//   the remainder unit and hands its remainder back. A set bit costs a
//   multiply, every bit below the top set bit a square. The result then
//   loads into the output register.
// Overlap: none; a new word is taken only once the core is idle again,
//   after the last result has gone into the output register.
//
// Reset clears the sequencer and the output valid flag. The result sits in
// an output register; if the receiver stalls, the core goes idle and takes
// the next word, but holds its next result until the register is free.
`default_nettype none

module modular_exponentiation_core (
    input  wire        i_clk,
    input  wire        i_rst_n,
    mexp_in_if.sink    i_in,
    mexp_out_if.source o_out
);
    import mexp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_STEP = 5'b00010,
        S_KICK = 5'b00100,
        S_WAIT = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    typedef enum logic [1:0] {
        TGT_RED = 2'd0,
        TGT_ACC = 2'd1,
        TGT_SQR = 2'd2
    } t_tgt;

    t_state            r_state;
    t_tgt              r_tgt;
    logic [EXP_W-1:0]  r_e;
    logic [MOD_W-1:0]  r_m;
    logic [MOD_W-1:0]  r_b;
    logic [RES_W-1:0]  r_acc;
    logic [PROD_W-1:0] r_prod;
    logic              r_mul_done;
    logic              r_err;
    logic              r_out_valid;
    logic [RES_W-1:0]  r_out_res;
    logic              r_out_err;

    t_mod_ctl          mod_ctl;
    t_mod_sts          mod_sts;
    logic              in_take;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_take    = i_in.valid && i_in.ready;

    always_comb begin
        mod_ctl.start    = (in_take && (i_in.modulus != '0)) || (r_state == S_KICK);
        mod_ctl.dividend = (r_state == S_IDLE) ? DVD_W'(i_in.base_value)
                                               : DVD_W'(r_prod);
        mod_ctl.modulus  = (r_state == S_IDLE) ? i_in.modulus : r_m;
    end

    mexp_mod_unit u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mod_ctl),
        .o_sts   (mod_sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // drop the word once taken, unless a new one loads this cycle
            if (r_out_valid && o_out.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_e        <= i_in.exponent_value;
                        r_m        <= i_in.modulus;
                        r_acc      <= RES_W'(1);
                        r_mul_done <= 1'b0;
                        r_tgt      <= TGT_RED;
                        if (i_in.modulus == '0) begin
                            r_err   <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_err   <= 1'b0;
                            r_state <= S_WAIT;
                        end
                    end
                end
                S_STEP: begin
                    priority if (r_e == '0) begin
                        r_state <= S_DONE;
                    end else if (r_e[0] && !r_mul_done) begin
                        r_prod  <= PROD_W'(r_acc) * PROD_W'(r_b);
                        r_tgt   <= TGT_ACC;
                        r_state <= S_KICK;
                    end else if (r_e[EXP_W-1:1] == '0) begin
                        // top bit handled; the last square is not needed
                        r_state <= S_DONE;
                    end else begin
                        r_prod  <= PROD_W'(r_b) * PROD_W'(r_b);
                        r_tgt   <= TGT_SQR;
                        r_state <= S_KICK;
                    end
                end
                S_KICK: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (mod_sts.done) begin
                        unique case (r_tgt)
                            TGT_RED: r_b <= mod_sts.rem;
                            TGT_ACC: begin
                                r_acc      <= mod_sts.rem;
                                r_mul_done <= 1'b1;
                            end
                            TGT_SQR: begin
                                r_b        <= mod_sts.rem;
                                r_e        <= r_e >> 1;
                                r_mul_done <= 1'b0;
                            end
                            default: r_b <= mod_sts.rem;
                        endcase
                        r_state <= S_STEP;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_res   <= r_err ? '0 : r_acc;
                        r_out_err   <= r_err;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.result_value  = r_out_res;
    assign o_out.modulus_error = r_out_err;

    // The sequencer never restarts the remainder unit while it is running
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_ctl.start |-> !mod_sts.busy)
        else $error("remainder unit restarted while busy");

    // Every reduction ends below the modulus of the current word
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_sts.done && (r_state == S_WAIT) |-> mod_sts.rem < r_m)
        else $error("remainder not below modulus");

    // An error result always carries a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_err |-> r_out_res == '0)
        else $error("modulus error with nonzero result");

endmodule

`default_nettype wire

>>> rtl/mexp_mod_unit.sv
// Bit-serial remainder unit: dividend mod modulus by restoring
// shift-and-subtract, one dividend bit per cycle. Depends on mexp_pkg.
`default_nettype none

module mexp_mod_unit (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  mexp_pkg::t_mod_ctl  i_ctl,
    output mexp_pkg::t_mod_sts  o_sts
);
    import mexp_pkg::*;

    logic [DVD_W-1:0] r_dvd;
    logic [MOD_W-1:0] r_rem;
    logic [MOD_W-1:0] r_mod;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [MOD_W:0]   n_shift;
    logic [MOD_W:0]   n_diff;
    logic [MOD_W-1:0] n_rem;

    always_comb begin
        n_shift = {r_rem, r_dvd[DVD_W-1]};
        n_diff  = n_shift - {1'b0, r_mod};
        // keep the partial remainder below the modulus
        n_rem   = (n_shift >= {1'b0, r_mod}) ? n_diff[MOD_W-1:0] : n_shift[MOD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_dvd  <= i_ctl.dividend;
                r_mod  <= i_ctl.modulus;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_sts.rem  = r_rem;

endmodule

`default_nettype wire

>>> verif/modular_exponentiation_core_tb.sv
`timescale 1ns / 1ps
// Testbench for modular_exponentiation_core: drives operand words, predicts
// base^exponent mod modulus and checks every result word in order.
// Depends on mexp_pkg, the channel interfaces in mexp_if and the core itself.

module modular_exponentiation_core_tb;

    import mexp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 5_000_000;
    localparam int unsigned LONG_STALL  = 20_000;
    localparam int unsigned TAIL_CYCLES = 16;
    localparam int unsigned RAND_WORDS  = 100;

    localparam bit [BASE_W-1:0] BASE_MAX = {BASE_W{1'b1}};
    localparam bit [EXP_W-1:0]  EXP_MAX  = {EXP_W{1'b1}};
    localparam bit [MOD_W-1:0]  MOD_MAX  = {MOD_W{1'b1}};

    // Holds the pending powers and compares result words against them.
    class power_book;
        typedef struct {
            bit [RES_W-1:0] value;
            bit             err;
        } t_power;

        t_power      pending_powers[$];
        int unsigned fails;

        function new();
            fails = 0;
        endfunction

        // Square-and-multiply from the exponent LSB upward.
        function void note_word(bit [BASE_W-1:0] b, bit [EXP_W-1:0] e, bit [MOD_W-1:0] m);
            t_power         p;
            bit [63:0]      sq;
            bit [63:0]      acc;
            bit [63:0]      mw;
            bit [EXP_W-1:0] bits;
            if (m == '0) begin
                p.value = '0;
                p.err   = 1'b1;
            end else begin
                mw   = {33'd0, m};
                sq   = {1'b0, b} % mw;
                acc  = 64'd1;
                bits = e;
                while (bits != '0) begin
                    if (bits[0])
                        acc = (acc * sq) % mw;
                    sq   = (sq * sq) % mw;
                    bits = bits >> 1;
                end
                p.value = acc[RES_W-1:0];
                p.err   = 1'b0;
            end
            pending_powers = {pending_powers, p};
        endfunction

        function void check_word(logic [RES_W-1:0] value, logic err);
            t_power p;
            if (pending_powers.size() == 0) begin
                $display("%0t: result word with nothing pending: value %0d error %b",
                         $time, value, err);
                fails++;
                return;
            end
            p = pending_powers.pop_front();
            if (value !== p.value) begin
                $display("%0t: result_value expected %0d actual %0d", $time, p.value, value);
                fails++;
            end
            if (err !== p.err) begin
                $display("%0t: modulus_error expected %b actual %b", $time, p.err, err);
                fails++;
            end
        endfunction

        function int pending();
            return pending_powers.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    mexp_in_if  in_ch ();
    mexp_out_if out_ch ();

    modular_exponentiation_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    power_book   book = new();
    int unsigned src_idle_pct = 8;
    int unsigned snk_idle_pct = 82;
    bit          hold_req = 1'b0;
    bit          hold_taken = 1'b0;
    int unsigned stall_left = 0;
    int unsigned cycle_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: random back-pressure, plus one long hold-off when asked.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            stall_left = LONG_STALL;
            out_ch.ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left = stall_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            book.check_word(out_ch.result_value, out_ch.modulus_error);
    end

    function automatic bit [62:0] rand63();
        return 63'({$urandom, $urandom});
    endfunction

    function automatic bit [62:0] rand_bits(int unsigned w);
        return rand63() & ((63'd1 << w) - 63'd1);
    endfunction

    function automatic bit [MOD_W-1:0] pick_modulus();
        int unsigned k;
        k = $urandom_range(99);
        if (k < 5)
            return '0;
        else if (k < 10)
            return 31'd1;
        else if (k < 20)
            return MOD_MAX;
        else if (k < 50)
            return 31'($urandom_range(1000, 2));
        else
            return 31'(rand_bits($urandom_range(31, 2)) | 63'd1);
    endfunction

    // Leave valid high when the next word follows at once; drop it only in a gap.
    task automatic offer_operands(input bit [BASE_W-1:0] b, input bit [EXP_W-1:0] e,
                                  input bit [MOD_W-1:0] m);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.base_value     <= b;
        in_ch.exponent_value <= e;
        in_ch.modulus        <= m;
        do
            @(posedge i_clk);
        while (!in_ch.ready);
        book.note_word(b, e, m);
    endtask

    task automatic offer_random();
        bit [MOD_W-1:0]  m;
        bit [BASE_W-1:0] b;
        bit [EXP_W-1:0]  e;
        int unsigned     k;
        m = pick_modulus();
        k = $urandom_range(99);
        if (k < 10)
            b = 63'(m) * 63'($urandom_range(5));
        else if (k < 40)
            b = rand_bits($urandom_range(31, 1));
        else
            b = rand63();
        k = $urandom_range(99);
        if (k < 10)
            e = '0;
        else if (k < 30)
            e = rand63();
        else
            e = rand_bits($urandom_range(16, 1));
        offer_operands(b, e, m);
    endtask

    initial begin
        in_ch.valid          <= 1'b0;
        in_ch.base_value     <= '0;
        in_ch.exponent_value <= '0;
        in_ch.modulus        <= '0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);

        // zero exponent, zero modulus, modulus one and the field extremes
        offer_operands(63'd5, 63'd0, 31'd1);
        offer_operands(63'd0, 63'd0, 31'd7);
        offer_operands(BASE_MAX, EXP_MAX, 31'd0);
        offer_operands(63'd0, 63'd0, 31'd0);
        offer_operands(63'd12345, 63'd7, 31'd1);
        offer_operands(BASE_MAX, EXP_MAX, MOD_MAX);
        offer_operands(63'd0, 63'd5, 31'd13);
        offer_operands(63'd2, 63'd10, 31'd1000);
        offer_operands(63'd97, 63'd3, 31'd97);
        offer_operands(BASE_MAX, 63'd1, MOD_MAX);
        offer_operands(63'd3, 63'd1 << 62, 31'd1000003);
        offer_operands(63'(MOD_MAX) - 63'd1, 63'd2, MOD_MAX);
        offer_operands(63'd1, EXP_MAX, 31'd2);
        offer_operands(63'd2, 63'h5555_5555_5555_5555, MOD_MAX);

        repeat (RAND_WORDS / 3) offer_random();

        src_idle_pct = 82;
        snk_idle_pct = 8;
        repeat (RAND_WORDS / 3) offer_random();

        // no idling, but the receiver holds off long enough to back up the core
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_req     = 1'b1;
        repeat (RAND_WORDS - 2 * (RAND_WORDS / 3)) offer_random();
        in_ch.valid <= 1'b0;

        while (book.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (book.fails == 0 && book.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
